>>> src/bitmap_page_frame_allocator_macros.svh
// Assertion macros for the page frame allocator.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define PFA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFA_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pfa_pkg.sv
// Shared constants, types and helpers of the page frame allocator.
// No dependencies.
`default_nettype none

package pfa_pkg;

    localparam int NUM_PAGES     = 65536;
    localparam int MAP_WORD_BITS = 32;
    localparam int PAGE_SHIFT    = 12;
    localparam int PAGE_BYTES    = 1 << PAGE_SHIFT;
    localparam int ADDR_W        = 48;
    localparam int CNT_W         = 32;
    localparam int KEP_W         = 17;

    localparam int MAP_WORDS  = (NUM_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WORD_IDX_W = $clog2(MAP_WORDS);
    localparam int BIT_W      = $clog2(MAP_WORD_BITS);
    localparam int PAGE_NUM_W = $clog2(NUM_PAGES + 1);
    localparam int SCAN_W     = $clog2(MAP_WORDS + 1);
    localparam int PFN_W      = ADDR_W + 1 - PAGE_SHIFT;

    localparam logic [SCAN_W-1:0]     SCAN_END  = SCAN_W'(MAP_WORDS);
    localparam logic [SCAN_W-1:0]     SCAN_LAST = SCAN_W'(MAP_WORDS - 1);
    localparam logic [PFN_W-1:0]      PFN_LIMIT = PFN_W'(NUM_PAGES);
    localparam logic [PAGE_NUM_W-1:0] PAGE_LIMIT = PAGE_NUM_W'(NUM_PAGES);

    localparam logic [1:0] MODE_REGION = 2'd0;
    localparam logic [1:0] MODE_ALLOC  = 2'd1;
    localparam logic [1:0] MODE_FREE   = 2'd2;

    typedef logic [MAP_WORD_BITS-1:0] map_word_t;
    typedef logic [BIT_W-1:0]         bit_idx_t;
    typedef logic [WORD_IDX_W-1:0]    word_idx_t;
    typedef logic [PAGE_NUM_W-1:0]    page_num_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    // range mask request for the word unit
    typedef struct packed {
        logic     lo_en;
        bit_idx_t lo_bit;
        logic     hi_en;
        bit_idx_t hi_bit;
    } wu_req_t;

    typedef struct packed {
        map_word_t set_word;
        map_word_t clr_word;
        logic      any;
        bit_idx_t  first;
    } wu_rsp_t;

    typedef enum logic [9:0] {
        ST_CLEAR     = 10'b00_0000_0001,
        ST_IDLE      = 10'b00_0000_0010,
        ST_REG_A     = 10'b00_0000_0100,
        ST_REG_B     = 10'b00_0000_1000,
        ST_REG_C     = 10'b00_0001_0000,
        ST_REG_RD    = 10'b00_0010_0000,
        ST_REG_WR    = 10'b00_0100_0000,
        ST_ALLOC_RD  = 10'b00_1000_0000,
        ST_ALLOC_CHK = 10'b01_0000_0000,
        ST_FREE      = 10'b10_0000_0000
    } state_t;

    function automatic cnt_t sat_add(input cnt_t c, input page_num_t n);
        logic [CNT_W:0] s;
        s = {1'b0, c} + (CNT_W + 1)'(n);
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> src/pfa_map_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the free map; no dependencies.
`default_nettype none

module pfa_map_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/pfa_word_unit.sv
// Shared map word unit: range set mask, lowest-set-bit search and clear.
// Depends on pfa_pkg.
`default_nettype none

module pfa_word_unit (
    input  wire pfa_pkg::map_word_t rdata,
    input  wire pfa_pkg::wu_req_t   req,
    output pfa_pkg::wu_rsp_t        rsp
);

    pfa_pkg::map_word_t lo_mask;
    pfa_pkg::map_word_t hi_mask;
    pfa_pkg::bit_idx_t  first;

    always_comb begin
        lo_mask = req.lo_en ? ({pfa_pkg::MAP_WORD_BITS{1'b1}} << req.lo_bit) : '1;
        hi_mask = req.hi_en
                ? ({pfa_pkg::MAP_WORD_BITS{1'b1}} >>
                   (pfa_pkg::BIT_W'(pfa_pkg::MAP_WORD_BITS - 1) - req.hi_bit))
                : '1;
    end

    // priority encoder, lowest index wins
    always_comb begin
        first = '0;
        for (int i = pfa_pkg::MAP_WORD_BITS - 1; i >= 0; i--) begin
            if (rdata[i]) begin
                first = pfa_pkg::BIT_W'(i);
            end
        end
    end

    always_comb begin
        rsp.set_word = rdata | (lo_mask & hi_mask);
        rsp.clr_word = rdata & ~(pfa_pkg::map_word_t'(1) << first);
        rsp.any      = |rdata;
        rsp.first    = first;
    end

endmodule

`default_nettype wire

>>> src/bitmap_page_frame_allocator.sv
// Channel   Dir  Handshake            Payload
// s_        in   s_valid / s_ready    s_mode, s_address, s_length, s_available
// m_        out  m_valid / m_ready    m_granted, m_page_address, m_free_count, m_total_count
// cfg_      in   cfg_we               cfg_wdata (kernel end page)
// After reset a clearing pass writes every map word (MAP_WORDS, 2048) with s_ready low.
// Region: REG_A, REG_B, REG_C, then per map word marked one RAM read, one word unit write.
// Allocate: map words are read and checked in turn from the lowest possibly-free word.
// Free: RAM read, then write if the bit was clear. Unused mode, unavailable region: REG_C only.
// The result sits in an output register; the next item is taken while it waits.
// Top level of the allocator; depends on pfa_pkg, pfa_map_ram, pfa_word_unit and the macros.
`default_nettype none
`include "bitmap_page_frame_allocator_macros.svh"

module bitmap_page_frame_allocator (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [pfa_pkg::KEP_W-1:0]    cfg_wdata,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [1:0]                   s_mode,
    input  wire logic [pfa_pkg::ADDR_W-1:0]   s_address,
    input  wire logic [pfa_pkg::ADDR_W-1:0]   s_length,
    input  wire logic                         s_available,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_granted,
    output logic [pfa_pkg::ADDR_W-1:0]        m_page_address,
    output logic [pfa_pkg::CNT_W-1:0]         m_free_count,
    output logic [pfa_pkg::CNT_W-1:0]         m_total_count
);

    pfa_pkg::state_t state_reg, state_next;

    logic [pfa_pkg::SCAN_W-1:0] ptr_reg;
    logic [pfa_pkg::SCAN_W-1:0] hint_reg;
    logic [pfa_pkg::KEP_W-1:0]  kep_reg;
    logic [pfa_pkg::ADDR_W-1:0] addr_reg;
    logic [pfa_pkg::ADDR_W-1:0] len_reg;
    pfa_pkg::page_num_t         start_reg;
    pfa_pkg::page_num_t         end_reg;
    pfa_pkg::page_num_t         ntot_reg;
    pfa_pkg::page_num_t         nfree_reg;
    pfa_pkg::word_idx_t         first_word_reg;
    pfa_pkg::word_idx_t         last_word_reg;
    pfa_pkg::bit_idx_t          lo_bit_reg;
    pfa_pkg::bit_idx_t          hi_bit_reg;
    pfa_pkg::cnt_t              free_cnt_reg;
    pfa_pkg::cnt_t              usable_cnt_reg;
    logic                       granted_reg;
    logic [pfa_pkg::ADDR_W-1:0] grant_addr_reg;

    logic                       m_valid_reg;
    logic                       m_granted_reg;
    logic [pfa_pkg::ADDR_W-1:0] m_page_address_reg;
    pfa_pkg::cnt_t              m_free_count_reg;
    pfa_pkg::cnt_t              m_total_count_reg;

    logic                   ram_we;
    pfa_pkg::word_idx_t     ram_waddr;
    pfa_pkg::map_word_t     ram_wdata;
    logic                   ram_re;
    pfa_pkg::word_idx_t     ram_raddr;
    pfa_pkg::map_word_t     ram_rdata;
    pfa_pkg::wu_req_t       wu_req;
    pfa_pkg::wu_rsp_t       wu_rsp;

    logic                        s_fire;
    logic                        out_free;
    logic                        out_load;
    logic [pfa_pkg::ADDR_W:0]    sum_start;
    logic [pfa_pkg::ADDR_W:0]    sum_end;
    logic [pfa_pkg::PFN_W-1:0]   pfn_start;
    logic [pfa_pkg::PFN_W-1:0]   pfn_end;
    pfa_pkg::page_num_t          lo_page;
    pfa_pkg::page_num_t          end_m1;
    logic [pfa_pkg::ADDR_W-1-pfa_pkg::PAGE_SHIFT:0] free_pfn;
    logic                        free_in_map;
    logic                        walk_last;

    assign s_ready  = (state_reg == pfa_pkg::ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == pfa_pkg::ST_REG_C) && (nfree_reg == '0) && out_free;

    assign m_valid        = m_valid_reg;
    assign m_granted      = m_granted_reg;
    assign m_page_address = m_page_address_reg;
    assign m_free_count   = m_free_count_reg;
    assign m_total_count  = m_total_count_reg;

    // region page bounds, free page index and last-word test
    always_comb begin
        sum_start = {1'b0, addr_reg} + (pfa_pkg::ADDR_W + 1)'(pfa_pkg::PAGE_BYTES - 1);
        sum_end   = {1'b0, addr_reg} + {1'b0, len_reg};
        pfn_start = sum_start[pfa_pkg::ADDR_W:pfa_pkg::PAGE_SHIFT];
        pfn_end   = sum_end[pfa_pkg::ADDR_W:pfa_pkg::PAGE_SHIFT];
        lo_page   = (start_reg > pfa_pkg::PAGE_NUM_W'(kep_reg))
                  ? start_reg : pfa_pkg::PAGE_NUM_W'(kep_reg);
        end_m1    = end_reg - 1'b1;
        free_pfn  = addr_reg[pfa_pkg::ADDR_W-1:pfa_pkg::PAGE_SHIFT];
        free_in_map = free_pfn < ($bits(free_pfn))'(pfa_pkg::NUM_PAGES);
        walk_last = (ptr_reg[pfa_pkg::WORD_IDX_W-1:0] == last_word_reg);
    end

    // RAM port and word unit steering
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg[pfa_pkg::WORD_IDX_W-1:0];
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = ptr_reg[pfa_pkg::WORD_IDX_W-1:0];
        wu_req.lo_en  = 1'b1;
        wu_req.lo_bit = lo_bit_reg;
        wu_req.hi_en  = 1'b1;
        wu_req.hi_bit = hi_bit_reg;
        case (state_reg)
            pfa_pkg::ST_CLEAR: begin
                ram_we = 1'b1;
            end
            pfa_pkg::ST_REG_RD: begin
                ram_re = 1'b1;
            end
            pfa_pkg::ST_REG_WR: begin
                wu_req.lo_en = (ptr_reg[pfa_pkg::WORD_IDX_W-1:0] == first_word_reg);
                wu_req.hi_en = walk_last;
                ram_we    = 1'b1;
                ram_wdata = wu_rsp.set_word;
            end
            pfa_pkg::ST_ALLOC_RD: begin
                ram_re = (ptr_reg != pfa_pkg::SCAN_END);
            end
            pfa_pkg::ST_ALLOC_CHK: begin
                ram_we    = wu_rsp.any;
                ram_wdata = wu_rsp.clr_word;
            end
            pfa_pkg::ST_FREE: begin
                // read issued on entry, write here when the page is in the map and its bit was clear
                ram_we    = free_in_map && !ram_rdata[lo_bit_reg];
                ram_wdata = wu_rsp.set_word;
            end
            default: begin
            end
        endcase
        if (state_reg == pfa_pkg::ST_IDLE && s_fire) begin
            ram_re    = (s_mode == pfa_pkg::MODE_FREE);
            ram_raddr = s_address[pfa_pkg::PAGE_SHIFT + pfa_pkg::BIT_W +: pfa_pkg::WORD_IDX_W];
        end
    end

    pfa_map_ram #(
        .DEPTH (pfa_pkg::MAP_WORDS),
        .WIDTH (pfa_pkg::MAP_WORD_BITS)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pfa_word_unit u_word_unit (
        .rdata (ram_rdata),
        .req   (wu_req),
        .rsp   (wu_rsp)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pfa_pkg::ST_CLEAR: begin
                if (ptr_reg == pfa_pkg::SCAN_LAST) state_next = pfa_pkg::ST_IDLE;
            end
            pfa_pkg::ST_IDLE: begin
                if (s_fire) begin
                    case (s_mode)
                        pfa_pkg::MODE_REGION:
                            state_next = s_available ? pfa_pkg::ST_REG_A : pfa_pkg::ST_REG_C;
                        pfa_pkg::MODE_ALLOC: state_next = pfa_pkg::ST_ALLOC_RD;
                        pfa_pkg::MODE_FREE:  state_next = pfa_pkg::ST_FREE;
                        default:             state_next = pfa_pkg::ST_REG_C;
                    endcase
                end
            end
            pfa_pkg::ST_REG_A: state_next = pfa_pkg::ST_REG_B;
            pfa_pkg::ST_REG_B: state_next = pfa_pkg::ST_REG_C;
            pfa_pkg::ST_REG_C: begin
                if (nfree_reg != '0) state_next = pfa_pkg::ST_REG_RD;
                else if (out_free)   state_next = pfa_pkg::ST_IDLE;
            end
            pfa_pkg::ST_REG_RD: state_next = pfa_pkg::ST_REG_WR;
            pfa_pkg::ST_REG_WR: begin
                if (!walk_last)    state_next = pfa_pkg::ST_REG_RD;
                else if (out_free) state_next = pfa_pkg::ST_REG_C;
                else               state_next = pfa_pkg::ST_REG_C;
            end
            pfa_pkg::ST_ALLOC_RD: begin
                if (ptr_reg != pfa_pkg::SCAN_END) state_next = pfa_pkg::ST_ALLOC_CHK;
                else                              state_next = pfa_pkg::ST_REG_C;
            end
            pfa_pkg::ST_ALLOC_CHK: begin
                state_next = wu_rsp.any ? pfa_pkg::ST_REG_C : pfa_pkg::ST_ALLOC_RD;
            end
            pfa_pkg::ST_FREE: state_next = pfa_pkg::ST_REG_C;
            default: state_next = pfa_pkg::ST_IDLE;
        endcase
    end

    // ST_REG_C doubles as the finishing step: counters are added once (nfree/ntot),
    // then cleared, so a later pass through it only waits for the output slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pfa_pkg::ST_CLEAR;
            ptr_reg        <= '0;
            hint_reg       <= pfa_pkg::SCAN_END;
            kep_reg        <= '0;
            free_cnt_reg   <= '0;
            usable_cnt_reg <= '0;
            m_valid_reg    <= 1'b0;
            ntot_reg       <= '0;
            nfree_reg      <= '0;
            granted_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) kep_reg <= cfg_wdata;
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;

            case (state_reg)
                pfa_pkg::ST_CLEAR: begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
                pfa_pkg::ST_IDLE: begin
                    if (s_fire) begin
                        addr_reg       <= s_address;
                        len_reg        <= s_length;
                        granted_reg    <= 1'b0;
                        grant_addr_reg <= '0;
                        ntot_reg       <= '0;
                        nfree_reg      <= '0;
                        if (s_mode == pfa_pkg::MODE_FREE) begin
                            // free item: capture page position at the transfer
                            ptr_reg    <= pfa_pkg::SCAN_W'(s_address[pfa_pkg::PAGE_SHIFT +
                                                             pfa_pkg::BIT_W +:
                                                             pfa_pkg::WORD_IDX_W]);
                            lo_bit_reg <= s_address[pfa_pkg::PAGE_SHIFT +: pfa_pkg::BIT_W];
                            hi_bit_reg <= s_address[pfa_pkg::PAGE_SHIFT +: pfa_pkg::BIT_W];
                        end else begin
                            ptr_reg    <= hint_reg;
                        end
                    end
                end
                pfa_pkg::ST_REG_A: begin
                    start_reg <= (pfn_start >= pfa_pkg::PFN_LIMIT)
                               ? pfa_pkg::PAGE_LIMIT : pfa_pkg::PAGE_NUM_W'(pfn_start);
                    end_reg   <= (pfn_end >= pfa_pkg::PFN_LIMIT)
                               ? pfa_pkg::PAGE_LIMIT : pfa_pkg::PAGE_NUM_W'(pfn_end);
                end
                pfa_pkg::ST_REG_B: begin
                    ntot_reg       <= (end_reg > start_reg) ? end_reg - start_reg : '0;
                    nfree_reg      <= (end_reg > lo_page) ? end_reg - lo_page : '0;
                    ptr_reg        <= pfa_pkg::SCAN_W'(lo_page >> pfa_pkg::BIT_W);
                    first_word_reg <= pfa_pkg::WORD_IDX_W'(lo_page >> pfa_pkg::BIT_W);
                    last_word_reg  <= pfa_pkg::WORD_IDX_W'(end_m1 >> pfa_pkg::BIT_W);
                    lo_bit_reg     <= lo_page[pfa_pkg::BIT_W-1:0];
                    hi_bit_reg     <= end_m1[pfa_pkg::BIT_W-1:0];
                end
                pfa_pkg::ST_REG_C: begin
                    usable_cnt_reg <= pfa_pkg::sat_add(usable_cnt_reg, ntot_reg);
                    ntot_reg       <= '0;
                    if (nfree_reg != '0) begin
                        free_cnt_reg <= pfa_pkg::sat_add(free_cnt_reg, nfree_reg);
                        nfree_reg    <= '0;
                        if (ptr_reg < hint_reg) hint_reg <= ptr_reg;
                    end else if (out_free) begin
                        m_granted_reg      <= granted_reg;
                        m_page_address_reg <= grant_addr_reg;
                        m_free_count_reg   <= free_cnt_reg;
                        m_total_count_reg  <= pfa_pkg::sat_add(usable_cnt_reg, ntot_reg);
                    end
                end
                pfa_pkg::ST_REG_WR: begin
                    if (!walk_last) ptr_reg <= ptr_reg + 1'b1;
                end
                pfa_pkg::ST_ALLOC_RD: begin
                    if (ptr_reg == pfa_pkg::SCAN_END) hint_reg <= pfa_pkg::SCAN_END;
                end
                pfa_pkg::ST_ALLOC_CHK: begin
                    if (wu_rsp.any) begin
                        granted_reg    <= 1'b1;
                        grant_addr_reg <= pfa_pkg::ADDR_W'({ptr_reg[pfa_pkg::WORD_IDX_W-1:0],
                                                            wu_rsp.first}) << pfa_pkg::PAGE_SHIFT;
                        if (free_cnt_reg != '0) free_cnt_reg <= free_cnt_reg - 1'b1;
                        hint_reg       <= ptr_reg;
                    end else begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                pfa_pkg::ST_FREE: begin
                    // page outside the map is ignored
                    if (free_in_map && !ram_rdata[lo_bit_reg]) begin
                        free_cnt_reg <= pfa_pkg::sat_add(free_cnt_reg, pfa_pkg::PAGE_NUM_W'(1));
                        if (ptr_reg < hint_reg) hint_reg <= ptr_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    `PFA_ASSERT_IMP(a_clear_blocks, state_reg == pfa_pkg::ST_CLEAR, !s_ready,
                    "item taken during clear")
    `PFA_ASSERT_IMP(a_clear_zero, state_reg == pfa_pkg::ST_CLEAR, ram_we && ram_wdata == '0,
                    "clear pass not writing zero")
    `PFA_ASSERT_IMP(a_nogrant_addr, m_valid_reg && !m_granted_reg, m_page_address_reg == '0,
                    "address without grant")
    `PFA_ASSERT_IMP(a_scan_bound, state_reg == pfa_pkg::ST_ALLOC_CHK,
                    ptr_reg < pfa_pkg::SCAN_END, "scan past map end")
    `PFA_ASSERT_NXT(a_done_loads, out_load, m_valid_reg, "result not loaded")

endmodule

`default_nettype wire

>>> tb/bitmap_page_frame_allocator_tb.sv
// Self-checking testbench for bitmap_page_frame_allocator: directed table, then random traffic.
// Replies are scored against an in-bench model of the page free map and its counters, or,
// for typed table rows, their given reply. Depends on pfa_pkg and the allocator RTL.
module bitmap_page_frame_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfa_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int OPENING_ROWS = 24;
    localparam int RANDOM_ITEMS = 1000;
    localparam int PHASES = 6;
    localparam logic [ADDR_W-1:0] ADDR_ALL = '1;

    typedef struct packed {
        logic              granted;
        logic [ADDR_W-1:0] page_addr;
        cnt_t              free_cnt;
        cnt_t              total_cnt;
    } frame_reply_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] length;
        logic              available;
        logic              typed;
        frame_reply_t      want;
    } frame_request_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_we;
    logic [KEP_W-1:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    logic [1:0] s_mode;
    logic [ADDR_W-1:0] s_address;
    logic [ADDR_W-1:0] s_length;
    logic s_available;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_granted;
    logic [ADDR_W-1:0] m_page_address;
    logic [CNT_W-1:0] m_free_count;
    logic [CNT_W-1:0] m_total_count;

    // travels alongside the payload so the scoreboard sees the row of the accepted transfer
    logic row_typed;
    frame_reply_t row_want;

    // model state
    map_word_t free_words [MAP_WORDS];
    cnt_t free_tally = '0;
    cnt_t usable_tally = '0;
    logic [KEP_W-1:0] kernel_end = '0;

    frame_reply_t predicted_replies [$];
    int mismatches = 0;
    logic quiet_run = 1'b0;
    int stall_left = 0;

    frame_request_t opening_rows [OPENING_ROWS] = '{
        '{MODE_ALLOC,  48'h0, 48'h0, 1'b0, 1'b1, '{1'b0, 48'h0, 32'd0, 32'd0}},
        '{MODE_UNUSED, ADDR_ALL, ADDR_ALL, 1'b1, 1'b1, '{1'b0, 48'h0, 32'd0, 32'd0}},
        '{MODE_REGION, 48'h0, ADDR_ALL, 1'b0, 1'b1, '{1'b0, 48'h0, 32'd0, 32'd0}},
        '{MODE_REGION, 48'h0, 48'h8000, 1'b1, 1'b1, '{1'b0, 48'h0, 32'd4, 32'd8}},
        '{MODE_ALLOC,  48'h0, 48'h0, 1'b0, 1'b1, '{1'b1, 48'h4000, 32'd3, 32'd8}},
        '{MODE_FREE,   48'h0, 48'h0, 1'b0, 1'b1, '{1'b0, 48'h0, 32'd4, 32'd8}},
        '{MODE_ALLOC,  48'h0, 48'h0, 1'b0, 1'b1, '{1'b1, 48'h0, 32'd3, 32'd8}},
        '{MODE_FREE,   48'h5FFF, 48'h0, 1'b0, 1'b1, '{1'b0, 48'h0, 32'd3, 32'd8}},
        '{MODE_FREE,   ADDR_ALL, 48'h0, 1'b0, 1'b1, '{1'b0, 48'h0, 32'd3, 32'd8}},
        '{MODE_FREE,   48'h0FFF_F000, 48'h0, 1'b0, 1'b1, '{1'b0, 48'h0, 32'd4, 32'd8}},
        '{MODE_REGION, 48'h0, 48'h8000, 1'b1, 1'b1, '{1'b0, 48'h0, 32'd8, 32'd16}},
        '{MODE_REGION, 48'h0, 48'h0, 1'b1, 1'b1, '{1'b0, 48'h0, 32'd8, 32'd16}},
        '{MODE_REGION, 48'h1_0001, 48'h3000, 1'b1, 1'b0, '0},
        '{MODE_REGION, ADDR_ALL, ADDR_ALL, 1'b1, 1'b0, '0},
        '{MODE_REGION, 48'h0FFF_F800, 48'h1000, 1'b1, 1'b0, '0},
        '{MODE_REGION, 48'h0FFF_E000, 48'h4000, 1'b1, 1'b0, '0},
        '{MODE_ALLOC,  48'h0, 48'h0, 1'b0, 1'b0, '0},
        '{MODE_REGION, 48'h0, ADDR_ALL, 1'b1, 1'b0, '0},
        '{MODE_ALLOC,  ADDR_ALL, ADDR_ALL, 1'b1, 1'b0, '0},
        '{MODE_ALLOC,  48'h0, 48'h0, 1'b0, 1'b0, '0},
        '{MODE_UNUSED, 48'h0, 48'h0, 1'b0, 1'b0, '0},
        '{MODE_FREE,   48'h1000, 48'h0, 1'b0, 1'b0, '0},
        '{MODE_REGION, 48'h0FFF, 48'h1, 1'b1, 1'b0, '0},
        '{MODE_FREE,   48'h4FFF, ADDR_ALL, 1'b1, 1'b0, '0}
    };

    bitmap_page_frame_allocator dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_address      (s_address),
        .s_length       (s_length),
        .s_available    (s_available),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_granted      (m_granted),
        .m_page_address (m_page_address),
        .m_free_count   (m_free_count),
        .m_total_count  (m_total_count)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic cnt_t bump(input cnt_t c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // mostly back-to-back, now and then a long pause
    function automatic int idle_span();
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet_run || pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 80);
    endfunction

    function automatic frame_reply_t frame_map_step(input logic [1:0] mode,
                                                    input logic [ADDR_W-1:0] address,
                                                    input logic [ADDR_W-1:0] length,
                                                    input logic available);
        frame_reply_t reply;
        logic [63:0] first_pg;
        logic [63:0] end_pg;
        logic [63:0] pg;
        logic found;
        reply = '0;
        found = 1'b0;
        case (mode)
            MODE_REGION: begin
                if (available) begin
                    first_pg = ({16'd0, address} + 64'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
                    end_pg = ({16'd0, address} + {16'd0, length}) >> PAGE_SHIFT;
                    if (end_pg > 64'(NUM_PAGES)) end_pg = 64'(NUM_PAGES);
                    for (pg = first_pg; pg < end_pg; pg++) begin
                        usable_tally = bump(usable_tally);
                        if (pg >= 64'(kernel_end)) begin
                            free_words[int'(pg / MAP_WORD_BITS)][int'(pg % MAP_WORD_BITS)] = 1'b1;
                            free_tally = bump(free_tally);
                        end
                    end
                end
            end
            MODE_ALLOC: begin
                for (int w = 0; w < MAP_WORDS && !found; w++) begin
                    if (free_words[w] != '0) begin
                        for (int b = 0; b < MAP_WORD_BITS && !found; b++) begin
                            if (free_words[w][b]) begin
                                found = 1'b1;
                                free_words[w][b] = 1'b0;
                                if (free_tally != '0) free_tally = free_tally - 1'b1;
                                reply.granted = 1'b1;
                                reply.page_addr = ADDR_W'(w * MAP_WORD_BITS + b) << PAGE_SHIFT;
                            end
                        end
                    end
                end
            end
            MODE_FREE: begin
                pg = {16'd0, address} >> PAGE_SHIFT;
                if (pg < 64'(NUM_PAGES)
                        && !free_words[int'(pg / MAP_WORD_BITS)][int'(pg % MAP_WORD_BITS)]) begin
                    free_words[int'(pg / MAP_WORD_BITS)][int'(pg % MAP_WORD_BITS)] = 1'b1;
                    free_tally = bump(free_tally);
                end
            end
            default: ;
        endcase
        reply.free_cnt = free_tally;
        reply.total_cnt = usable_tally;
        return reply;
    endfunction

    function automatic frame_request_t random_request();
        frame_request_t req;
        int pick;
        int shape;
        int jitter;
        pick = $urandom_range(0, 99);
        jitter = $urandom_range(0, 1) ? $urandom_range(0, PAGE_BYTES - 1) : 0;
        req.address = rand48();
        req.length = rand48();
        req.available = 1'($urandom_range(0, 1));
        req.typed = 1'b0;
        req.want = '0;
        if (pick < 38) begin
            req.mode = MODE_REGION;
            req.available = ($urandom_range(0, 9) != 0);
            shape = $urandom_range(0, 99);
            // small regions low in the map keep allocation scans short
            if (shape < 85) begin
                req.address = (ADDR_W'($urandom_range(0, 4095)) << PAGE_SHIFT) + ADDR_W'(jitter);
                req.length = (ADDR_W'($urandom_range(0, 64)) << PAGE_SHIFT)
                           + ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
            end else if (shape >= 97) begin
                req.address = ADDR_W'($urandom_range(0, NUM_PAGES - 1)) << PAGE_SHIFT;
            end
        end else if (pick < 73) begin
            req.mode = MODE_ALLOC;
        end else if (pick < 95) begin
            req.mode = MODE_FREE;
            if ($urandom_range(0, 4) != 0)
                req.address = (ADDR_W'($urandom_range(0, 4095)) << PAGE_SHIFT) + ADDR_W'(jitter);
        end else begin
            req.mode = MODE_UNUSED;
        end
        return req;
    endfunction

    task automatic push_request(input frame_request_t req);
        int gap;
        gap = idle_span();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= req.mode;
        s_address <= req.address;
        s_length <= req.length;
        s_available <= req.available;
        row_typed <= req.typed;
        row_want <= req.want;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic await_replies();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (predicted_replies.size() != 0) @(posedge aclk);
    endtask

    task automatic set_kernel_end(input logic [KEP_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        kernel_end = value;
    endtask

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (!quiet_run && $urandom_range(0, 9) == 0) begin
            stall_left <= idle_span();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : scoreboard
        frame_reply_t seen;
        frame_reply_t want;
        frame_reply_t model;
        if (aresetn && m_valid && m_ready) begin
            seen = '{m_granted, m_page_address, m_free_count, m_total_count};
            if (predicted_replies.size() == 0) begin
                $error("result transfer with nothing outstanding");
                mismatches++;
            end else begin
                want = predicted_replies.pop_front();
                if (seen.granted !== want.granted) begin
                    $error("granted: expected %0d, got %0d", want.granted, seen.granted);
                    mismatches++;
                end
                if (seen.page_addr !== want.page_addr) begin
                    $error("page_address: expected %0h, got %0h", want.page_addr, seen.page_addr);
                    mismatches++;
                end
                if (seen.free_cnt !== want.free_cnt) begin
                    $error("free_count: expected %0d, got %0d", want.free_cnt, seen.free_cnt);
                    mismatches++;
                end
                if (seen.total_cnt !== want.total_cnt) begin
                    $error("total_count: expected %0d, got %0d", want.total_cnt, seen.total_cnt);
                    mismatches++;
                end
            end
        end
        // model advances on every accepted transfer, typed rows included
        if (aresetn && s_valid && s_ready) begin
            model = frame_map_step(s_mode, s_address, s_length, s_available);
            predicted_replies.push_back(row_typed ? row_want : model);
        end
    end

    initial begin
        #100_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [KEP_W-1:0] phase_kernel [PHASES];
        foreach (free_words[w]) free_words[w] = '0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_mode = MODE_REGION;
        s_address = '0;
        s_length = '0;
        s_available = 1'b0;
        row_typed = 1'b0;
        row_want = '0;
        phase_kernel = '{17'd0, 17'h1_0000, 17'h0_FFFF, 17'd0, 17'd1, 17'd0};
        phase_kernel[3] = KEP_W'($urandom_range(2, 2048));
        phase_kernel[5] = KEP_W'($urandom_range(0, NUM_PAGES));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        // pages 0..3 stand in for the kernel image during the table
        set_kernel_end(KEP_W'(4));

        foreach (opening_rows[i]) push_request(opening_rows[i]);
        await_replies();

        for (int ph = 0; ph < PHASES; ph++) begin
            repeat (4) @(posedge aclk);
            set_kernel_end(phase_kernel[ph]);
            quiet_run = (ph % 3 == 1);
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) push_request(random_request());
            await_replies();
        end

        repeat (16) @(posedge aclk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/pfa_pkg.sv
src/pfa_map_ram.sv
src/pfa_word_unit.sv
src/bitmap_page_frame_allocator.sv
tb/bitmap_page_frame_allocator_tb.sv
